// ----- hw/rtl/bwsc_pkg.sv -----
// Shared types, codes and sizes for the byte-window send credit engine.
package bwsc_pkg;

  // Table and identifier sizes
  localparam int MAX_OUTSTANDING = 32;
  localparam int ID_BITS         = 16;
  localparam int IDX_W   = (MAX_OUTSTANDING > 1) ? $clog2(MAX_OUTSTANDING) : 1;
  localparam int TREE_N  = 1 << IDX_W;
  localparam int CNT_W   = $clog2(TREE_N + 1);
  localparam int SUM_W   = 16 + IDX_W;
  localparam int STEP_W  = $clog2(IDX_W + 1);

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Reset values of the registers
  localparam logic [15:0] PACKET_SIZE_RST   = 16'd1400;
  localparam logic [23:0] WINDOW_SIZE_RST   = 24'd25000;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;

  // Register indexes
  localparam logic [1:0] CFG_PACKET_SIZE   = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Opcodes on the input word
  localparam logic [1:0] OPC_SEND = 2'd0;
  localparam logic [1:0] OPC_ACK  = 2'd1;
  localparam logic [1:0] OPC_TICK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_WINDOW_FULL = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN_ID  = 2'd3;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_TICK,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] ack_id;
    logic [15:0] link_accept_bytes;
  } in_word_t;

  typedef struct packed {
    logic        sent;
    logic [15:0] send_bytes;
    logic [15:0] send_id;
    logic [23:0] window_fill;
    logic [5:0]  freed_count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] packet_size;
    logic [23:0] window_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Classified command as it sits in the queue
  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] ack_id;
    logic [15:0] accept_bytes;
  } cmd_t;

endpackage

// ----- hw/rtl/byte_window_send_credit.sv -----
// Top level of the byte-window send credit engine.
//
// A command word is taken at a rising edge with start high and busy low; a
// two-word command queue sits behind the port, so busy rises only when both
// queue slots are taken. Each word gives exactly one result, shown on out_data
// for a single cycle while out_valid is high; the receiver cannot hold it off.
// The execution unit handles one word at a time: a send slot or an ack is
// first sized or id-matched across all 32 table entries, then updates the table
// and fill; a timer tick counts down all entries in parallel, sums the expired
// bytes through five levels of a registered adder tree, then updates the fill;
// an unused opcode is answered directly from idle. Each result passes through a
// result register. Register writes on the cfg port are always taken
// (cfg_ready is high) and must be made only while no word is in progress.
module byte_window_send_credit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bwsc_pkg::in_word_t  in_data,
  output logic                out_valid,
  output bwsc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  bwsc_pkg::cfg_t  cfg_r;
  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  bwsc_pkg::cmd_t  push_cmd;
  bwsc_pkg::cmd_t  pop_cmd;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_size   <= bwsc_pkg::PACKET_SIZE_RST;
      cfg_r.window_size   <= bwsc_pkg::WINDOW_SIZE_RST;
      cfg_r.timeout_ticks <= bwsc_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bwsc_pkg::CFG_PACKET_SIZE:   cfg_r.packet_size   <= cfg_data[15:0];
        bwsc_pkg::CFG_WINDOW_SIZE:   cfg_r.window_size   <= cfg_data;
        bwsc_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  bwsc_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .cmd     (push_cmd)
  );

  bwsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  bwsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/bwsc_front.sv -----
// Front end: takes input words and classifies them into queue commands.
module bwsc_front (
  input  logic               start,
  input  bwsc_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output bwsc_pkg::cmd_t     cmd
);

  // Hold off the sender while the queue has no room
  assign busy = q_full;
  assign push = start && !q_full;

  // Decode the opcode into a command kind
  always_comb begin
    cmd.ack_id       = in_data.ack_id;
    cmd.accept_bytes = in_data.link_accept_bytes;
    unique case (in_data.opcode)
      bwsc_pkg::OPC_SEND: cmd.kind = bwsc_pkg::OP_SEND;
      bwsc_pkg::OPC_ACK:  cmd.kind = bwsc_pkg::OP_ACK;
      bwsc_pkg::OPC_TICK: cmd.kind = bwsc_pkg::OP_TICK;
      default:            cmd.kind = bwsc_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/bwsc_queue.sv -----
// Short command queue between the front end and the execution back end.
module bwsc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bwsc_pkg::cmd_t push_data,
  input  logic           pop,
  output bwsc_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  bwsc_pkg::cmd_t                 mem_r [bwsc_pkg::QDEPTH];
  logic [bwsc_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [bwsc_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [bwsc_pkg::QCNT_W-1:0]    count_r;
  logic                           do_push;
  logic                           do_pop;

  assign full     = (count_r == bwsc_pkg::QCNT_W'(bwsc_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == bwsc_pkg::QPTR_W'(bwsc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == bwsc_pkg::QPTR_W'(bwsc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/bwsc_back.sv -----
// Back end: runs send, ack and tick commands against the in-flight table and answers unused opcodes.
module bwsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bwsc_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  bwsc_pkg::cmd_t      q_data,
  output logic                pop,
  output logic                out_valid,
  output bwsc_pkg::out_word_t out_data
);

  localparam int N = bwsc_pkg::MAX_OUTSTANDING;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_ACK,
    S_TICK,
    S_DONE
  } state_t;

  state_t                           state_r;
  logic [N-1:0]                     valid_r;
  logic [23:0]                      fill_r;
  logic [15:0]                      next_size_r;
  logic [15:0]                      leftover_r;
  logic [bwsc_pkg::ID_BITS-1:0]     next_id_r;
  logic [bwsc_pkg::STEP_W-1:0]      step_r;
  logic                             out_valid_r;
  bwsc_pkg::out_word_t              out_data_r;

  // Table payload, written only where valid is set
  logic [bwsc_pkg::ID_BITS-1:0]     id_r    [N];
  logic [15:0]                      bytes_r [N];
  logic [15:0]                      cd_r    [N];

  // Take-cycle results held for the update in S_SEND or S_ACK
  logic [15:0]                      to_send_r;
  logic [15:0]                      accept_r;
  logic [bwsc_pkg::IDX_W-1:0]       slot_r;
  logic                             slot_ok_r;
  logic [bwsc_pkg::IDX_W-1:0]       hit_idx_r;
  logic                             hit_ok_r;

  // Registered adder tree for expired bytes and count
  logic [bwsc_pkg::SUM_W-1:0]       tree_sum_r [bwsc_pkg::TREE_N];
  logic [bwsc_pkg::CNT_W-1:0]       tree_cnt_r [bwsc_pkg::TREE_N];

  logic [23:0]                      avail;
  logic [15:0]                      to_send;
  logic [N-1:0]                     match;
  logic [bwsc_pkg::IDX_W-1:0]       slot;
  logic                             slot_ok;
  logic [bwsc_pkg::IDX_W-1:0]       hit_idx;
  logic                             hit_ok;
  logic [15:0]                      cd_dec [N];
  logic [N-1:0]                     expire;
  logic [15:0]                      actual;
  logic [15:0]                      hit_bytes;
  logic                             take;

  assign take      = (state_r == S_IDLE) && !q_empty;
  assign pop       = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Size the send from the free window
  always_comb begin
    avail   = (cfg.window_size > fill_r) ? cfg.window_size - fill_r : '0;
    to_send = ({8'b0, next_size_r} < avail) ? next_size_r : avail[15:0];
  end

  // Match ack id and find the lowest free entry
  always_comb begin
    slot    = '0;
    slot_ok = 1'b0;
    hit_idx = '0;
    hit_ok  = 1'b0;
    for (int k = 0; k < N; k++) begin
      match[k] = valid_r[k] && (32'(id_r[k]) == 32'(q_data.ack_id));
    end
    for (int k = N - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        slot    = bwsc_pkg::IDX_W'(k);
        slot_ok = 1'b1;
      end
      if (match[k]) begin
        hit_idx = bwsc_pkg::IDX_W'(k);
        hit_ok  = 1'b1;
      end
    end
  end

  // Count down every entry and flag those that expire
  always_comb begin
    for (int k = 0; k < N; k++) begin
      cd_dec[k] = (cd_r[k] != 16'd0) ? cd_r[k] - 16'd1 : 16'd0;
      expire[k] = valid_r[k] && (cd_dec[k] == 16'd0);
    end
  end

  assign actual    = (accept_r < to_send_r) ? accept_r : to_send_r;
  assign hit_bytes = bytes_r[hit_idx_r];

  // Sequence commands, update control state and drive the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fill_r      <= '0;
      next_size_r <= bwsc_pkg::PACKET_SIZE_RST;
      leftover_r  <= '0;
      next_id_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (q_data.kind)
              bwsc_pkg::OP_SEND: state_r <= S_SEND;
              bwsc_pkg::OP_ACK:  state_r <= S_ACK;
              bwsc_pkg::OP_TICK: begin
                valid_r <= valid_r & ~expire;
                step_r  <= '0;
                state_r <= S_TICK;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_data_r  <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                                 window_fill: fill_r, freed_count: '0,
                                 status: bwsc_pkg::ST_OK};
              end
            endcase
          end
        end
        S_SEND: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          if (to_send_r == 16'd0) begin
            next_size_r <= (leftover_r != 16'd0) ? leftover_r : cfg.packet_size;
            out_data_r  <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                             window_fill: fill_r, freed_count: '0,
                             status: bwsc_pkg::ST_WINDOW_FULL};
          end else if (!slot_ok_r) begin
            out_data_r  <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                             window_fill: fill_r, freed_count: '0,
                             status: bwsc_pkg::ST_TABLE_FULL};
          end else begin
            valid_r[slot_r] <= 1'b1;
            next_id_r       <= next_id_r + 1'b1;
            fill_r          <= fill_r + {8'b0, actual};
            if (actual != to_send_r) begin
              leftover_r  <= to_send_r - actual;
              next_size_r <= to_send_r - actual;
            end else begin
              leftover_r  <= '0;
              next_size_r <= cfg.packet_size;
            end
            out_data_r <= '{sent: 1'b1, send_bytes: actual, send_id: 16'(next_id_r),
                            window_fill: fill_r + {8'b0, actual}, freed_count: '0,
                            status: bwsc_pkg::ST_OK};
          end
        end
        S_ACK: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          if (!hit_ok_r) begin
            out_data_r <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                            window_fill: fill_r, freed_count: '0,
                            status: bwsc_pkg::ST_UNKNOWN_ID};
          end else begin
            valid_r[hit_idx_r] <= 1'b0;
            next_size_r        <= cfg.packet_size;
            fill_r             <= (fill_r >= {8'b0, hit_bytes}) ?
                                  fill_r - {8'b0, hit_bytes} : '0;
            out_data_r <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                            window_fill: (fill_r >= {8'b0, hit_bytes}) ?
                                         fill_r - {8'b0, hit_bytes} : '0,
                            freed_count: 6'd1, status: bwsc_pkg::ST_OK};
          end
        end
        S_TICK: begin
          step_r <= step_r + 1'b1;
          if (step_r == bwsc_pkg::STEP_W'(bwsc_pkg::IDX_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
          if (tree_cnt_r[0] != '0) begin
            next_size_r <= cfg.packet_size;
          end
          fill_r     <= (24'(tree_sum_r[0]) <= fill_r) ? fill_r - 24'(tree_sum_r[0]) : '0;
          out_data_r <= '{sent: 1'b0, send_bytes: '0, send_id: '0,
                          window_fill: (24'(tree_sum_r[0]) <= fill_r) ?
                                       fill_r - 24'(tree_sum_r[0]) : '0,
                          freed_count: 6'(tree_cnt_r[0]), status: bwsc_pkg::ST_OK};
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold table payload, take-cycle results and the adder tree
  always_ff @(posedge clk) begin
    if (take) begin
      to_send_r <= to_send;
      accept_r  <= q_data.accept_bytes;
      slot_r    <= slot;
      slot_ok_r <= slot_ok;
      hit_idx_r <= hit_idx;
      hit_ok_r  <= hit_ok;
      if (q_data.kind == bwsc_pkg::OP_TICK) begin
        for (int k = 0; k < bwsc_pkg::TREE_N; k++) begin
          if (k < N) begin
            if (valid_r[k]) begin
              cd_r[k] <= cd_dec[k];
            end
            tree_sum_r[k] <= expire[k] ? bwsc_pkg::SUM_W'(bytes_r[k]) : '0;
            tree_cnt_r[k] <= expire[k] ? bwsc_pkg::CNT_W'(1) : '0;
          end else begin
            tree_sum_r[k] <= '0;
            tree_cnt_r[k] <= '0;
          end
        end
      end
    end
    // Record a new packet in the chosen free entry
    if (state_r == S_SEND && to_send_r != 16'd0 && slot_ok_r) begin
      id_r[slot_r]    <= next_id_r;
      bytes_r[slot_r] <= actual;
      cd_r[slot_r]    <= cfg.timeout_ticks;
    end
    // Fold the tree one level per cycle
    if (state_r == S_TICK) begin
      for (int i = 0; i < bwsc_pkg::TREE_N / 2; i++) begin
        tree_sum_r[i] <= tree_sum_r[2*i] + tree_sum_r[2*i+1];
        tree_cnt_r[i] <= tree_cnt_r[2*i] + tree_cnt_r[2*i+1];
      end
    end
  end

endmodule
